// ===== src/gem_pkg.sv =====
`timescale 1ns / 1ps
// gem_pkg: shared types, constants and helpers for the gradient energy map.
// No dependencies.
package gem_pkg;

  localparam int PIX_W        = 8;
  localparam int IMG_W_BITS   = 11;
  localparam int IMG_H_BITS   = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int ENERGY_W     = 9;

  localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 11'd640;
  localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = 16'd480;

  // Configuration register indexes
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Decoupling queue, power of two
  localparam int QUEUE_DEPTH = 4;

  // Classification of one queued item
  typedef struct packed {
    logic row0;        // first row of frame: fill line store only
    logic last_col;    // last column of the row
    logic last_row;    // pending row is the frame's last
    logic use_centre;  // lower neighbour replicates the centre
  } item_flags_t;

  // One line store word: row above and pending row at one column
  typedef struct packed {
    logic [PIX_W-1:0] older;
    logic [PIX_W-1:0] newer;
  } line_word_t;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== src/gem_ram.sv =====
`timescale 1ns / 1ps
// gem_ram: generic single write, dual read RAM with registered read data.
// No dependencies.
module gem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ===== src/gem_front.sv =====
`timescale 1ns / 1ps
// gem_front: takes input transfers, tracks row and column, classifies items.
// Depends on gem_pkg.
module gem_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [gem_pkg::PIX_W-1:0]         in_pixel,
  input  logic                              in_drain,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]    w_eff,
  input  logic [gem_pkg::IMG_H_BITS-1:0]    h_eff,
  output logic                              push,
  output logic [$clog2(MAX_WIDTH)-1:0]      push_col,
  output logic [gem_pkg::PIX_W-1:0]         push_pix,
  output gem_pkg::item_flags_t              push_flags
);
  import gem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [CW-1:0]         col_r, col_nxt;
  logic [IMG_H_BITS-1:0] row_r, row_nxt;
  logic [WW-1:0]         col_inc;
  logic                  accept, row0, last_col, last_row;

  assign accept   = in_valid && !in_stall;
  assign col_inc  = WW'(col_r) + WW'(1);
  assign last_col = (col_inc >= w_eff);
  assign row0     = (row_r == '0);
  assign last_row = !row0 && (row_r >= h_eff);

  // A drain during the first row has nothing to flush
  assign push                  = accept && !(row0 && in_drain);
  assign push_col              = col_r;
  assign push_pix              = in_pixel;
  assign push_flags.row0       = row0;
  assign push_flags.last_col   = last_col;
  assign push_flags.last_row   = last_row;
  assign push_flags.use_centre = in_drain || last_row;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (push) begin
      if (last_col) begin
        col_nxt = '0;
        if (row0) begin
          row_nxt = IMG_H_BITS'(1);
        end else if (last_row) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + IMG_H_BITS'(1);
        end
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

// ===== src/gem_queue.sv =====
`timescale 1ns / 1ps
// gem_queue: short FIFO between front and back.
// Depends on gem_pkg (depth).
module gem_queue #(
  parameter int DW = 24
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output logic [DW-1:0] head_data
);
  import gem_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [DW-1:0] store_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == NW'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = store_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r + NW'(do_push) - NW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= NW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (full && !pop) |=> full)
    else $error("queue lost an entry while full");

endmodule

// ===== src/gem_back.sv =====
`timescale 1ns / 1ps
// gem_back: line store access, energy calculation and output register.
// Depends on gem_pkg and gem_ram.
module gem_back #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            head_valid,
  input  logic [$clog2(MAX_WIDTH)-1:0]    head_col,
  input  logic [gem_pkg::PIX_W-1:0]       head_pix,
  input  gem_pkg::item_flags_t            head_flags,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gem_pkg::ENERGY_W-1:0]    out_energy_half,
  output logic [gem_pkg::PIX_W-1:0]       out_energy_byte,
  output logic                            out_end_of_row,
  output logic                            out_end_of_frame
);
  import gem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  // Execute stage
  logic              s2_valid_r, s2_valid_nxt;
  logic [CW-1:0]     s2_col_r;
  logic [PIX_W-1:0]  s2_pix_r;
  item_flags_t       s2_flags_r;
  // Forwarding of a write that lands in the same cycle as the read
  logic              byp_a_r, byp_b_r;
  line_word_t        byp_data_r;
  logic [PIX_W-1:0]  pleft_r;
  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [ENERGY_W-1:0] energy_r;
  logic              eor_r, eof_r;

  logic [CW-1:0]     raddr_a, raddr_b;
  line_word_t        rdata_a, rdata_b, word_c, word_r;
  logic [PIX_W-1:0]  centre, up, down, left_px, right_px;
  logic [ENERGY_W-1:0] energy;
  line_word_t        wdata;
  logic              out_free, s2_fire, load_out;

  assign raddr_a = head_col;
  assign raddr_b = head_flags.last_col ? head_col : head_col + CW'(1);

  gem_ram #(
    .WIDTH ($bits(line_word_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .we      (s2_fire),
    .waddr   (s2_col_r),
    .wdata   (wdata),
    .re      (pop),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign word_c   = byp_a_r ? byp_data_r : rdata_a;
  assign word_r   = byp_b_r ? byp_data_r : rdata_b;
  assign centre   = word_c.newer;
  assign up       = word_c.older;
  assign down     = s2_flags_r.use_centre ? centre : s2_pix_r;
  assign left_px  = (s2_col_r != '0) ? pleft_r : centre;
  assign right_px = s2_flags_r.last_col ? centre : word_r.newer;
  assign energy   = {1'b0, abs_diff(up, down)} + {1'b0, abs_diff(left_px, right_px)};

  always_comb begin
    if (s2_flags_r.row0) begin
      wdata.older = s2_pix_r;
      wdata.newer = s2_pix_r;
    end else begin
      wdata.older = centre;
      wdata.newer = down;
    end
  end

  assign out_free     = !out_valid_r || !out_stall;
  assign s2_fire      = s2_valid_r && (s2_flags_r.row0 || out_free);
  assign load_out     = s2_fire && !s2_flags_r.row0;
  assign pop          = head_valid && (!s2_valid_r || s2_fire);
  assign s2_valid_nxt = pop || (s2_valid_r && !s2_fire);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s2_valid_r  <= s2_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s2_col_r   <= head_col;
      s2_pix_r   <= head_pix;
      s2_flags_r <= head_flags;
      byp_a_r    <= s2_fire && (s2_col_r == raddr_a);
      byp_b_r    <= s2_fire && (s2_col_r == raddr_b);
      byp_data_r <= wdata;
    end
    if (s2_fire) begin
      pleft_r <= centre;
    end
    if (load_out) begin
      energy_r <= energy;
      eor_r    <= s2_flags_r.last_col;
      eof_r    <= s2_flags_r.last_col && s2_flags_r.last_row;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_energy_half  = energy_r;
  assign out_energy_byte  = energy_r[ENERGY_W-1:1];
  assign out_end_of_row   = eor_r;
  assign out_end_of_frame = eof_r;

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !s2_fire) |=> (s2_valid_r && $stable(s2_col_r) && $stable(s2_pix_r)))
    else $error("execute stage changed while held");

  a_row0_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && s2_flags_r.row0 && !out_valid_r) |=> !out_valid_r)
    else $error("first-row item produced a result");

  a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && eof_r) |-> eor_r)
    else $error("end of frame without end of row");

endmodule

// ===== src/gradient_energy_map.sv =====
`timescale 1ns / 1ps
// gradient_energy_map: top level of the streaming gradient energy block.
// Depends on gem_pkg, gem_front, gem_queue, gem_back (and gem_ram below it).
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in_     | into      | in_valid/in_stall  | in_pixel[7:0], in_drain
//  out_    | out of    | out_valid/out_stall| out_energy_half[8:0], out_energy_byte,
//          |           |                    | out_end_of_row, out_end_of_frame
//  cfg_    | into      | cfg_we             | cfg_index, cfg_wdata[15:0]
//
// One item per clock unless out_stall holds; results pass the queue and execute
// stage to the output register. The single line store RAM (one write, two reads
// per cycle) is what sets this rate: each item reads its column and the next.
// Reset is synchronous and active low; it clears counters and valids and presets
// the size registers; the line store is not cleared (the first row of a frame
// fills it). in_stall rises only when the four-entry queue is full; out_stall
// holds the output register and, through the queue, eventually the input.
module gradient_energy_map #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // pixel input
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [gem_pkg::PIX_W-1:0]        in_pixel,
  input  logic                             in_drain,
  // energy output
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gem_pkg::ENERGY_W-1:0]     out_energy_half,
  output logic [gem_pkg::PIX_W-1:0]        out_energy_byte,
  output logic                             out_end_of_row,
  output logic                             out_end_of_frame,
  // configuration writes
  input  logic                             cfg_we,
  input  logic                             cfg_index,
  input  logic [gem_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import gem_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int EW = (WW > IMG_W_BITS) ? WW : IMG_W_BITS;
  localparam int QW = CW + PIX_W + $bits(item_flags_t);

  // Configuration registers
  logic [IMG_W_BITS-1:0] image_width_r, image_width_nxt;
  logic [IMG_H_BITS-1:0] image_height_r, image_height_nxt;

  always_comb begin
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_nxt  = cfg_wdata[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height_nxt = cfg_wdata[IMG_H_BITS-1:0];
        default:          image_width_nxt  = image_width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= IMG_W_RESET;
      image_height_r <= IMG_H_RESET;
    end else begin
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
    end
  end

  // Effective sizes: zero reads as one, width saturates at the line store depth
  logic [EW-1:0]         w_ext;
  logic [WW-1:0]         w_eff;
  logic [IMG_H_BITS-1:0] h_eff;

  assign w_ext = EW'(image_width_r);

  always_comb begin
    if (image_width_r == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext[WW-1:0];
    end
  end

  assign h_eff = (image_height_r == '0) ? IMG_H_BITS'(1) : image_height_r;

  // Front: count position, classify, drop drains with nothing to flush
  logic              push, q_full, q_pop, q_valid;
  logic [CW-1:0]     push_col, head_col;
  logic [PIX_W-1:0]  push_pix, head_pix;
  item_flags_t       push_flags, head_flags;
  logic [QW-1:0]     q_head;

  assign in_stall = q_full;

  gem_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pixel   (in_pixel),
    .in_drain   (in_drain),
    .w_eff      (w_eff),
    .h_eff      (h_eff),
    .push       (push),
    .push_col   (push_col),
    .push_pix   (push_pix),
    .push_flags (push_flags)
  );

  // Queue decouples classification from the line store pipeline
  gem_queue #(
    .DW (QW)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({push_col, push_pix, push_flags}),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  assign {head_col, head_pix, head_flags} = q_head;

  // Back: read line store, compute energy, update store, present result
  gem_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_valid),
    .head_col         (head_col),
    .head_pix         (head_pix),
    .head_flags       (head_flags),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_energy_half  (out_energy_half),
    .out_energy_byte  (out_energy_byte),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame)
  );

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for gradient_energy_map, with its own energy predictor.
// Depends on gem_pkg and gradient_energy_map from the RTL; needs nothing else.
module testbench;

  localparam int LINE_MAX      = 1024;      // line store depth of the instance
  localparam int TOTAL_ITEMS   = 1800;      // counted transfers over the whole run
  localparam int SETTLE_CYCLES = 16;        // margin for results still inside the block
  localparam int CYCLE_LIMIT   = 1000000;   // several times the slowest legal run

  // One result as the output channel carries it
  typedef struct packed {
    logic [gem_pkg::ENERGY_W-1:0] energy_half;
    logic [gem_pkg::PIX_W-1:0]    energy_byte;
    logic                         end_of_row;
    logic                         end_of_frame;
  } energy_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BURSTY, STALL_PERIODIC} stall_mode_t;

  // Energy predictor and store of expected results. Holds its own copy of both
  // line stores, the row/column position and the two geometry registers.
  class energy_scoreboard;
    logic [7:0]  line_above [LINE_MAX];    // row above the pending row
    logic [7:0]  line_pending [LINE_MAX];  // pending row, emitted one row late
    int unsigned row_cnt;                  // index of the row now arriving
    int unsigned col_cnt;
    int unsigned width_reg;
    int unsigned height_reg;
    int unsigned frames_done;
    int unsigned counted_items;            // transfers that the block does not ignore
    int unsigned errors;
    energy_t     expected_q[$];

    function new();
      foreach (line_above[i]) begin
        line_above[i]   = '0;
        line_pending[i] = '0;
      end
      row_cnt       = 0;
      col_cnt       = 0;
      width_reg     = 640;
      height_reg    = 480;
      frames_done   = 0;
      counted_items = 0;
      errors        = 0;
    endfunction

    // zero is taken as one, and the width saturates at the line store depth
    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_MAX) return LINE_MAX;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // the pending row is the frame's last: whatever arrives now only flushes it
    function bit flushing();
      return row_cnt != 0 && row_cnt >= eff_height();
    endfunction

    function void write_reg(logic idx, logic [gem_pkg::CFG_DATA_W-1:0] data);
      if (idx == gem_pkg::REG_IMAGE_WIDTH) width_reg = 32'(data & 16'h07FF);
      else height_reg = 32'(data);
    endfunction

    function void note_input(logic [7:0] pix, logic drain);
      int unsigned w, h, c, centre, up, down, left, right, dv, dh;
      bit          last_col, last_row;
      energy_t     res;
      w = eff_width();
      h = eff_height();
      c = (col_cnt >= LINE_MAX) ? LINE_MAX - 1 : col_cnt;
      last_col = (c + 1 >= w);
      // first row only fills the stores; a drain there has nothing to flush
      if (row_cnt == 0) begin
        if (drain) return;
        counted_items++;
        line_above[c]   = pix;
        line_pending[c] = pix;
        if (last_col) begin
          col_cnt = 0;
          row_cnt = 1;
        end else begin
          col_cnt = c + 1;
        end
        return;
      end
      counted_items++;
      last_row = (row_cnt >= h);
      centre   = 32'(line_pending[c]);
      up       = 32'(line_above[c]);
      // below the last row, and on a drain, the lower neighbour is the centre
      down     = (last_row || drain) ? centre : 32'(pix);
      left     = (c > 0) ? 32'(line_above[c - 1]) : centre;
      right    = (!last_col && c + 1 < LINE_MAX) ? 32'(line_pending[c + 1]) : centre;
      dv       = (up > down) ? up - down : down - up;
      dh       = (left > right) ? left - right : right - left;
      res.energy_half  = 9'(dv + dh);
      res.energy_byte  = 8'((dv + dh) >> 1);
      res.end_of_row   = last_col;
      res.end_of_frame = last_col && last_row;
      expected_q.push_back(res);
      line_above[c]   = 8'(centre);
      line_pending[c] = 8'(down);
      if (last_col) begin
        col_cnt = 0;
        if (last_row) begin
          row_cnt = 0;
          frames_done++;
        end else begin
          row_cnt = (row_cnt + 1) & 16'hFFFF;
        end
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void check_result(energy_t got);
      energy_t want;
      if (expected_q.size() == 0) begin
        $error("result with no transfer awaiting it: energy_half %0d", got.energy_half);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.energy_half !== want.energy_half) begin
        $error("energy_half: expected %0d, got %0d", want.energy_half, got.energy_half);
        errors++;
      end
      if (got.energy_byte !== want.energy_byte) begin
        $error("energy_byte: expected %0d, got %0d", want.energy_byte, got.energy_byte);
        errors++;
      end
      if (got.end_of_row !== want.end_of_row) begin
        $error("end_of_row: expected %0d, got %0d", want.end_of_row, got.end_of_row);
        errors++;
      end
      if (got.end_of_frame !== want.end_of_frame) begin
        $error("end_of_frame: expected %0d, got %0d", want.end_of_frame, got.end_of_frame);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Block signals, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [gem_pkg::PIX_W-1:0]       in_pixel = '0;
  logic                            in_drain = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [gem_pkg::ENERGY_W-1:0]    out_energy_half;
  logic [gem_pkg::PIX_W-1:0]       out_energy_byte;
  logic                            out_end_of_row;
  logic                            out_end_of_frame;
  logic                            cfg_we = 1'b0;
  logic                            cfg_index = gem_pkg::REG_IMAGE_WIDTH;
  logic [gem_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  energy_scoreboard sb;
  stall_mode_t      stall_mode = STALL_NONE;
  bit               gaps_on = 1'b0;     // sender works in bursts when set
  int               burst_left = 0;
  int               stall_run = 0;
  bit               stall_hold = 1'b0;
  int unsigned      stall_tick = 0;
  int unsigned      cycles = 0;

  gradient_energy_map #(
    .MAX_WIDTH(LINE_MAX)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_pixel         (in_pixel),
    .in_drain         (in_drain),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_energy_half  (out_energy_half),
    .out_energy_byte  (out_energy_byte),
    .out_end_of_row   (out_end_of_row),
    .out_end_of_frame (out_end_of_frame),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop: a hang or a lost handshake ends here
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver back-pressure. Each mode gives its own stall pattern; the mode is
  // changed per phase, and STALL_NONE gives stretches with no stalls at all.
  always @(posedge clk) begin
    case (stall_mode)
      STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_BURSTY: begin
        if (stall_run == 0) begin
          stall_hold = !stall_hold;
          stall_run  = stall_hold ? $urandom_range(1, 12) : $urandom_range(1, 20);
        end
        stall_run--;
        out_stall <= stall_hold;
      end
      STALL_PERIODIC: begin
        stall_tick++;
        out_stall <= ((stall_tick % 7) < 2);
      end
      default: out_stall <= 1'b0;
    endcase
  end

  // Every result transfer is checked against the oldest expectation.
  // Values read here are the ones present before the edge.
  always @(posedge clk) begin : result_monitor
    energy_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.energy_half  = out_energy_half;
      seen.energy_byte  = out_energy_byte;
      seen.end_of_row   = out_end_of_row;
      seen.end_of_frame = out_end_of_frame;
      sb.check_result(seen);
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // One input transfer. In burst mode a random gap (now and then a long one)
  // opens before each burst. Payload is held until the transfer completes.
  task automatic send_item(input logic [7:0] pix, input logic drain);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 32);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    in_drain <= drain;
    do @(posedge clk); while (in_stall);
    sb.note_input(pix, drain);
    if (burst_left > 0) burst_left--;
  endtask

  // Sender pauses until every expected result has come out
  task automatic hold_until_empty();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  // Idle point for register writes: first-row transfers give no result, so
  // the block may still be busy after the last result; allow its latency.
  task automatic settle_idle();
    hold_until_empty();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[gem_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
    sb.write_reg(idx, value[gem_pkg::CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // extremes weighted in
  function automatic logic [7:0] any_pixel();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Feed items until the predictor sees the frame close. Inside the frame a
  // few drains break the pixel sequence; once the last row is pending the
  // flush is mostly drains, with some pixels whose value must be ignored.
  task automatic run_frame(input int noise_pct);
    int unsigned goal;
    logic        drain;
    goal = sb.frames_done + 1;
    while (sb.frames_done < goal) begin
      if (sb.flushing()) drain = ($urandom_range(0, 3) != 0);
      else drain = ($urandom_range(0, 99) < noise_pct);
      send_item(any_pixel(), drain);
      if ($urandom_range(0, 299) == 0) hold_until_empty();
    end
  endtask

  task automatic pick_idling();
    gaps_on    = ($urandom_range(0, 3) != 0);
    burst_left = 0;
    stall_mode <= stall_mode_t'($urandom_range(0, 3));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned w, h, frames;
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: 3 x 2 frame with full-scale steps, a drain on the first row
    // (ignored), a drain inside the frame, a pause until all results are out,
    // and a flush that starts with a pixel whose value must not matter.
    gaps_on = 1'b1;
    stall_mode <= STALL_RANDOM;
    cfg_write(gem_pkg::REG_IMAGE_WIDTH, 3);
    cfg_write(gem_pkg::REG_IMAGE_HEIGHT, 2);
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0); send_item(8'h00, 1'b0); send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0); send_item(8'hFF, 1'b1); send_item(8'hFF, 1'b0);
    hold_until_empty();
    send_item(8'h5A, 1'b0); send_item(8'h00, 1'b1); send_item(8'h00, 1'b1);
    settle_idle();

    // single pixel frame
    cfg_write(gem_pkg::REG_IMAGE_WIDTH, 1);
    cfg_write(gem_pkg::REG_IMAGE_HEIGHT, 1);
    send_item(8'hFF, 1'b0); send_item(8'h00, 1'b1);
    settle_idle();

    // zero width and height act as one; flush by a pixel
    cfg_write(gem_pkg::REG_IMAGE_WIDTH, 0);
    cfg_write(gem_pkg::REG_IMAGE_HEIGHT, 0);
    send_item(8'h80, 1'b0); send_item(8'h07, 1'b0);
    settle_idle();

    // 2 x 3 with extremes, a checkerboard in the first two rows
    cfg_write(gem_pkg::REG_IMAGE_WIDTH, 2);
    cfg_write(gem_pkg::REG_IMAGE_HEIGHT, 3);
    send_item(8'hFF, 1'b0); send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b0); send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0); send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1); send_item(8'h00, 1'b1);
    settle_idle();

    // Widest setting: all width bits set, saturates at the line store depth.
    // The first row fills every column; the width is then narrowed while idle,
    // so a short flush gives results only if that row closed at the depth.
    gaps_on = 1'b0;
    stall_mode <= STALL_NONE;
    cfg_write(gem_pkg::REG_IMAGE_WIDTH, 32'h07FF);
    cfg_write(gem_pkg::REG_IMAGE_HEIGHT, 1);
    repeat (LINE_MAX) send_item(any_pixel(), 1'b0);
    settle_idle();
    cfg_write(gem_pkg::REG_IMAGE_WIDTH, 3);
    run_frame(0);
    settle_idle();

    // Tallest setting, then the height lowered mid-frame while idle: the
    // frame must close at the end of the next row.
    pick_idling();
    cfg_write(gem_pkg::REG_IMAGE_WIDTH, $urandom_range(1, 4));
    cfg_write(gem_pkg::REG_IMAGE_HEIGHT, 32'hFFFF);
    repeat (12 * sb.eff_width()) send_item(any_pixel(), 1'b0);
    settle_idle();
    cfg_write(gem_pkg::REG_IMAGE_HEIGHT, 3);
    run_frame(4);
    settle_idle();

    // Random phases: mostly small frames, some medium, few wide. Upper bits
    // of the width write are junk that the register must drop.
    while (sb.counted_items < TOTAL_ITEMS) begin
      pick_idling();
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: w = $urandom_range(1, 8);
        6, 7:             w = $urandom_range(9, 40);
        8:                w = $urandom_range(41, 160);
        default:          w = $urandom_range(1, 2);
      endcase
      h = ($urandom_range(0, 9) < 6) ? $urandom_range(1, 4) : $urandom_range(5, 10);
      cfg_write(gem_pkg::REG_IMAGE_WIDTH, w | ($urandom_range(0, 31) << 11));
      cfg_write(gem_pkg::REG_IMAGE_HEIGHT, h);
      frames = $urandom_range(1, 3);
      repeat (frames) run_frame($urandom_range(0, 8));
      settle_idle();
    end

    if (sb.expected_q.size() != 0) begin
      $error("%0d expected results never arrived", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
